// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate implication, checked every cycle out of reset
`define FCSG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// antecedent this cycle, consequent on the next cycle
`define FCSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/fcsg_pkg.sv
`default_nettype none

package fcsg_pkg;

    localparam int XY_W   = 11;
    localparam int OUT_W  = 12;
    localparam int RAD_W  = 6;
    localparam int IDX_W  = 6;
    localparam int PROD_W = 11;
    localparam int ROOT_W = 6;

    typedef struct packed {
        logic [XY_W-1:0]  center_x;
        logic [XY_W-1:0]  center_y;
        logic [RAD_W-1:0] radius;
    } t_circle;

    typedef struct packed {
        logic [OUT_W-1:0] row_y;
        logic [OUT_W-1:0] left_x;
        logic [OUT_W-1:0] right_x;
        logic             last_span;
    } t_span;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

endpackage

`default_nettype wire

// File: rtl/filled_circle_span_generator.sv
// a circle passes the input queue, the sequencer load and the s1 register before its first span enters the result queue
// throughput: one span per cycle while the result queue has room; a circle of radius r gives 2*r spans,
// issued by the span sequencer after it loads the circle
// a zero radius circle is dropped at the input
// reset: synchronous active low, empties both queues and idles the sequencer
`default_nettype none

`include "assert_macros.svh"

module filled_circle_span_generator #(
    parameter int MAX_RADIUS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [fcsg_pkg::XY_W-1:0]     i_center_x,
    input  wire logic [fcsg_pkg::XY_W-1:0]     i_center_y,
    input  wire logic [fcsg_pkg::RAD_W-1:0]    i_circle_radius,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [fcsg_pkg::OUT_W-1:0]         o_row_y,
    output logic [fcsg_pkg::OUT_W-1:0]         o_left_x,
    output logic [fcsg_pkg::OUT_W-1:0]         o_right_x,
    output logic                               o_last_span
);

    localparam int RES_DEPTH = 4;

    fcsg_pkg::t_circle               w_q_head;
    logic [fcsg_pkg::RAD_W-1:0]      w_q_radius;
    logic                            w_q_empty;
    logic                            w_q_pop;
    logic [$clog2(RES_DEPTH):0]      w_res_count;
    logic                            w_res_full;
    logic                            w_span_push;
    fcsg_pkg::t_span                 w_span;
    fcsg_pkg::t_span                 w_res_head;

    fcsg_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .o_full          (full),
        .i_q_pop         (w_q_pop),
        .o_q_head        (w_q_head),
        .o_q_empty       (w_q_empty)
    );

    fcsg_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_head    (w_q_head),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .i_res_count (w_res_count),
        .o_span_push (w_span_push),
        .o_span      (w_span)
    );

    fcsg_fifo #(
        .WIDTH ($bits(fcsg_pkg::t_span)),
        .DEPTH (RES_DEPTH)
    ) u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_span_push),
        .i_data  (w_span),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign w_res_full  = (w_res_count == ($clog2(RES_DEPTH)+1)'(RES_DEPTH));
    assign w_q_radius  = w_q_head.radius;

    assign o_row_y     = w_res_head.row_y;
    assign o_left_x    = w_res_head.left_x;
    assign o_right_x   = w_res_head.right_x;
    assign o_last_span = w_res_head.last_span;

    `FCSG_ASSERT(a_res_no_overflow, w_span_push |-> !w_res_full)
    `FCSG_ASSERT(a_queue_radius_ok, !w_q_empty |-> (w_q_radius != '0 && w_q_radius <= MAX_RADIUS))
    `FCSG_ASSERT(a_pop_only_nonempty, w_q_pop |-> !w_q_empty)
    `FCSG_ASSERT_NEXT(a_load_then_run, w_q_pop, !w_q_pop)

endmodule

`default_nettype wire

// File: rtl/fcsg_fifo.sv
`default_nettype none

// DEPTH must be a power of two, pointers wrap on their own
module fcsg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire logic [WIDTH-1:0]         i_data,
    input  wire logic                     i_pop,
    output logic      [WIDTH-1:0]         o_data,
    output logic                          o_empty,
    output logic      [$clog2(DEPTH):0]   o_count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW:0]      n_count;
    logic             w_full;
    logic             w_do_push;
    logic             w_do_pop;

    assign w_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !w_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count + (AW+1)'(w_do_push) - (AW+1)'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fcsg_front.sv
`default_nettype none

module fcsg_front #(
    parameter int MAX_RADIUS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [fcsg_pkg::XY_W-1:0]     i_center_x,
    input  wire logic [fcsg_pkg::XY_W-1:0]     i_center_y,
    input  wire logic [fcsg_pkg::RAD_W-1:0]    i_circle_radius,
    output logic                               o_full,
    input  wire logic                          i_q_pop,
    output fcsg_pkg::t_circle                  o_q_head,
    output logic                               o_q_empty
);

    localparam int Q_DEPTH = 2;

    logic [fcsg_pkg::RAD_W-1:0]  w_radius;
    logic                        w_keep;
    fcsg_pkg::t_circle           w_circle;
    logic [$clog2(Q_DEPTH):0]    w_q_count;

    // clamp the radius, a zero radius gives no spans and never enters the queue
    always_comb begin
        if (i_circle_radius > fcsg_pkg::RAD_W'(MAX_RADIUS)) begin
            w_radius = fcsg_pkg::RAD_W'(MAX_RADIUS);
        end else begin
            w_radius = i_circle_radius;
        end
        w_keep            = (w_radius != '0);
        w_circle.center_x = i_center_x;
        w_circle.center_y = i_center_y;
        w_circle.radius   = w_radius;
    end

    assign o_full = (w_q_count == ($clog2(Q_DEPTH)+1)'(Q_DEPTH));

    fcsg_fifo #(
        .WIDTH ($bits(fcsg_pkg::t_circle)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_keep),
        .i_data  (w_circle),
        .i_pop   (i_q_pop),
        .o_data  (o_q_head),
        .o_empty (o_q_empty),
        .o_count (w_q_count)
    );

endmodule

`default_nettype wire

// File: rtl/fcsg_back.sv
`default_nettype none

module fcsg_back #(
    parameter int RES_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fcsg_pkg::t_circle              i_q_head,
    input  wire logic                           i_q_empty,
    output logic                                o_q_pop,
    input  wire logic [$clog2(RES_DEPTH):0]     i_res_count,
    output logic                                o_span_push,
    output fcsg_pkg::t_span                     o_span
);

    localparam int CW = $clog2(RES_DEPTH) + 1;
    localparam int XY_W   = fcsg_pkg::XY_W;
    localparam int OUT_W  = fcsg_pkg::OUT_W;
    localparam int RAD_W  = fcsg_pkg::RAD_W;
    localparam int IDX_W  = fcsg_pkg::IDX_W;
    localparam int PROD_W = fcsg_pkg::PROD_W;
    localparam int ROOT_W = fcsg_pkg::ROOT_W;

    fcsg_pkg::t_seq_state r_state;
    fcsg_pkg::t_seq_state n_state;

    logic [XY_W-1:0]   r_cx;
    logic [XY_W-1:0]   r_cy;
    logic [RAD_W-1:0]  r_radius;
    logic [IDX_W-1:0]  r_idx;

    logic              r_s1_valid;
    logic [OUT_W-1:0]  r_s1_row;
    logic [XY_W-1:0]   r_s1_cx;
    logic [PROD_W-1:0] r_s1_prod;
    logic              r_s1_last;

    logic              w_room;
    logic              w_issue;
    logic              w_last;
    logic [IDX_W:0]    w_two_r;
    logic [IDX_W:0]    w_diff;
    logic [2*IDX_W+1:0] w_prod;
    logic [OUT_W-1:0]  w_row;
    logic [ROOT_W-1:0] w_half;

    // restoring square root, two radicand bits per step, rounds down
    function automatic logic [ROOT_W-1:0] f_isqrt(input logic [PROD_W-1:0] n);
        logic [2*ROOT_W-1:0] v;
        logic [2*ROOT_W+1:0] rem;
        logic [2*ROOT_W+1:0] trial;
        logic [ROOT_W-1:0]   root;
        begin
            v    = {{(2*ROOT_W-PROD_W){1'b0}}, n};
            rem  = '0;
            root = '0;
            for (int i = ROOT_W - 1; i >= 0; i--) begin
                rem   = {rem[2*ROOT_W-1:0], v[2*i+1 -: 2]};
                trial = {{ROOT_W{1'b0}}, root, 2'b01};
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[ROOT_W-2:0], 1'b1};
                end else begin
                    root = {root[ROOT_W-2:0], 1'b0};
                end
            end
            return root;
        end
    endfunction

    // a span is issued only if the result queue has a slot for it and the one in flight
    assign w_room  = (i_res_count + CW'(r_s1_valid)) < CW'(RES_DEPTH);
    assign w_issue = (r_state == fcsg_pkg::ST_RUN) && w_room;

    always_comb begin
        w_two_r = {r_radius, 1'b0};
        w_diff  = w_two_r - {1'b0, r_idx};
        w_prod  = {1'b0, r_idx} * w_diff;
        w_last  = (({1'b0, r_idx} + (IDX_W+1)'(1)) == w_two_r);
        w_row   = {r_cy[XY_W-1], r_cy} + OUT_W'(r_radius) - OUT_W'(r_idx);
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            fcsg_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = fcsg_pkg::ST_RUN;
                end
            end
            fcsg_pkg::ST_RUN: begin
                if (w_issue && w_last) begin
                    n_state = fcsg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fcsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fcsg_pkg::ST_IDLE;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cx     <= i_q_head.center_x;
            r_cy     <= i_q_head.center_y;
            r_radius <= i_q_head.radius;
            r_idx    <= '0;
        end else if (w_issue) begin
            r_idx    <= r_idx + IDX_W'(1);
        end
        if (w_issue) begin
            r_s1_row  <= w_row;
            r_s1_cx   <= r_cx;
            r_s1_prod <= w_prod[PROD_W-1:0];
            r_s1_last <= w_last;
        end
    end

    assign w_half = f_isqrt(r_s1_prod);

    always_comb begin
        o_span_push      = r_s1_valid;
        o_span.row_y     = r_s1_row;
        o_span.left_x    = {r_s1_cx[XY_W-1], r_s1_cx} - OUT_W'(w_half);
        o_span.right_x   = {r_s1_cx[XY_W-1], r_s1_cx} + OUT_W'(w_half);
        o_span.last_span = r_s1_last;
    end

endmodule

`default_nettype wire
